// ===== rtl/dfd_pkg.sv =====
// Package for the decimated feedback delay: configuration codes, reset values,
// the configuration record, command and status types and the saturation helpers.
// No dependencies; every other file but dfd_ram refers to it by scoped names.
package dfd_pkg;

  localparam int LINE_LENGTH = 1280;

  localparam int SAMPLE_W = 12;
  localparam int WORD_W   = 16;
  localparam int ENTRY_W  = 8;
  localparam int COEF_W   = 8;
  localparam int LEN_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIMATION   = 3'd0,
    CFG_FILTER_GAIN  = 3'd1,
    CFG_DELAY_LENGTH = 3'd2,
    CFG_FEEDBACK     = 3'd3,
    CFG_WET_AMOUNT   = 3'd4,
    CFG_RAW_MODE     = 3'd5
  } cfg_idx_e;

  localparam logic [COEF_W-1:0] DECIMATION_RST   = 8'd1;
  localparam logic [COEF_W-1:0] FILTER_GAIN_RST  = 8'd255;
  localparam logic [LEN_W-1:0]  DELAY_LENGTH_RST = 11'd1280;
  localparam logic [COEF_W-1:0] FEEDBACK_RST     = 8'd0;
  localparam logic [COEF_W-1:0] WET_AMOUNT_RST   = 8'd0;

  typedef struct packed {
    logic [COEF_W-1:0] decimation;
    logic [COEF_W-1:0] filter_gain;
    logic [LEN_W-1:0]  delay_length;
    logic [COEF_W-1:0] feedback;
    logic [COEF_W-1:0] wet_amount;
    logic              raw_mode;
  } cfg_t;

  // One bit for the clearing pass and one for each step of the item sequence.
  typedef struct packed {
    logic clr;
    logic accept;
    logic tap;
    logic fb;
    logic upd_in;
    logic upd_out;
    logic wet;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

  function automatic logic signed [WORD_W-1:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[WORD_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip12(input logic signed [17:0] v);
    if (v > 18'sd2047) begin
      return 12'sh7ff;
    end else if (v < -18'sd2048) begin
      return 12'sh800;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== rtl/dfd_if.sv =====
// Channel interfaces of the decimated feedback delay: sample input, sample
// output and configuration write. Depends on dfd_pkg for the field widths.
interface dfd_in_if;
  logic valid;
  logic ready;
  logic signed [dfd_pkg::SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface dfd_out_if;
  logic valid;
  logic ready;
  logic signed [dfd_pkg::SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface dfd_cfg_if;
  logic valid;
  logic ready;
  logic [dfd_pkg::CFG_IDX_W-1:0]  index;
  logic [dfd_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/dfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1280
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dfd_ctrl.sv =====
// Sequencer of the decimated feedback delay: clearing pass, item steps and the
// output register handshake. Depends on dfd_pkg for the command and status types.
module dfd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dfd_pkg::sts_t sts_i,
  output dfd_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_TAP     = 8'b0000_0100,
    ST_FB      = 8'b0000_1000,
    ST_UPD_IN  = 8'b0001_0000,
    ST_UPD_OUT = 8'b0010_0000,
    ST_WET     = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.clr     = (state_q == ST_CLEAR);
    cmd_o.accept  = accept;
    cmd_o.tap     = (state_q == ST_TAP);
    cmd_o.fb      = (state_q == ST_FB);
    cmd_o.upd_in  = (state_q == ST_UPD_IN);
    cmd_o.upd_out = (state_q == ST_UPD_OUT);
    cmd_o.wet     = (state_q == ST_WET);
    cmd_o.load    = load;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:    if (accept) state_d = ST_TAP;
      ST_TAP:     state_d = ST_FB;
      ST_FB:      state_d = ST_UPD_IN;
      ST_UPD_IN:  state_d = ST_UPD_OUT;
      ST_UPD_OUT: state_d = ST_WET;
      ST_WET:     state_d = ST_FIN;
      ST_FIN:     if (load) state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted sample passes the tap, fb, update and wet steps, then the final step.
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 (state_q == ST_FIN))
    else $error("item did not reach the final step on time");

  // The output register is never overwritten while it holds an untaken result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // The clearing pass ends only after its last entry has been written.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ST_CLEAR) |-> $past(sts_i.clr_last))
    else $error("clearing pass ended early");

endmodule

// ===== rtl/dfd_datapath.sv =====
// Datapath of the decimated feedback delay: line memory, tap address, feedback,
// the two one-pole smoothers and the wet mix. Depends on dfd_pkg and dfd_ram.
module dfd_datapath #(
  parameter int LineLength = dfd_pkg::LINE_LENGTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dfd_pkg::cfg_t                        cfg_i,
  input  dfd_pkg::cmd_t                        cmd_i,
  output dfd_pkg::sts_t                        sts_o,
  input  logic signed [dfd_pkg::SAMPLE_W-1:0]  sample_i,
  output logic signed [dfd_pkg::SAMPLE_W-1:0]  sample_o
);

  localparam int IW = $clog2(LineLength);
  localparam int EW = ((IW > dfd_pkg::LEN_W) ? IW : dfd_pkg::LEN_W) + 2;
  localparam logic [EW-1:0] LEN_E  = EW'(LineLength);
  localparam logic [IW-1:0] LAST_I = IW'(LineLength - 1);

  logic [IW-1:0] wi_q, clr_cnt_q;
  logic [dfd_pkg::COEF_W-1:0] decim_q;
  logic access, access_q;
  logic signed [dfd_pkg::SAMPLE_W-1:0] sample_q, out_q;
  logic signed [dfd_pkg::WORD_W-1:0] si_q, so_q, last_tap_q, d_in_q, d_out_q;
  logic signed [16:0] prod_fb_q;
  logic signed [24:0] prod_in_q, prod_out_q, prod_wet_q;

  logic [EW-1:0] len_e, span, rd_sum;
  logic [IW-1:0] rd_idx;
  logic signed [dfd_pkg::ENTRY_W-1:0] tap;
  logic [dfd_pkg::ENTRY_W-1:0] rdata;
  logic signed [dfd_pkg::WORD_W-1:0] s16, line_in, fb, wet_src;
  logic signed [8:0] gain_s, fbk_s, wet_s;
  logic ram_we;
  logic [IW-1:0] ram_waddr;
  logic [dfd_pkg::ENTRY_W-1:0] ram_wdata;

  assign access = (decim_q >= cfg_i.decimation);

  // A distance of zero or beyond the line reads the entry about to be written.
  assign len_e  = EW'(cfg_i.delay_length);
  assign span   = ((len_e == '0) || (len_e >= LEN_E)) ? LEN_E : len_e;
  assign rd_sum = EW'(wi_q) + LEN_E - span;
  assign rd_idx = (rd_sum >= LEN_E) ? IW'(rd_sum - LEN_E) : IW'(rd_sum);

  assign tap     = $signed(rdata);
  assign s16     = {sample_q, 4'b0000};
  assign gain_s  = $signed({1'b0, cfg_i.filter_gain});
  assign fbk_s   = $signed({1'b0, cfg_i.feedback});
  assign wet_s   = $signed({1'b0, cfg_i.wet_amount});
  assign line_in = cfg_i.raw_mode ? s16 : si_q;
  assign fb      = dfd_pkg::sat16(18'(line_in) + 18'($signed(prod_fb_q[16:8])));
  assign wet_src = cfg_i.raw_mode ? last_tap_q : so_q;

  assign ram_we    = cmd_i.clr || (cmd_i.fb && access_q);
  assign ram_waddr = cmd_i.clr ? clr_cnt_q : wi_q;
  assign ram_wdata = cmd_i.clr ? '0 : fb[dfd_pkg::WORD_W-1:8];

  dfd_ram #(
    .Width(dfd_pkg::ENTRY_W),
    .Depth(LineLength)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx),
    .rdata_o(rdata)
  );

  assign sts_o.clr_last = (clr_cnt_q == LAST_I);
  assign sample_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      wi_q       <= '0;
      decim_q    <= '0;
      access_q   <= 1'b0;
      si_q       <= '0;
      so_q       <= '0;
      last_tap_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        access_q <= access;
        decim_q  <= (access ? '0 : decim_q) + 1'b1;
      end
      if (cmd_i.tap && access_q) begin
        last_tap_q <= 16'(tap) <<< 4;
      end
      if (cmd_i.fb && access_q) begin
        wi_q <= (wi_q == LAST_I) ? '0 : wi_q + 1'b1;
      end
      if (cmd_i.upd_in && !cfg_i.raw_mode) begin
        si_q <= dfd_pkg::sat16(18'(si_q) + 18'($signed(prod_in_q[24:8])));
      end
      if (cmd_i.upd_out && !cfg_i.raw_mode) begin
        so_q <= dfd_pkg::sat16(18'(so_q) + 18'($signed(prod_out_q[24:8])));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.tap) begin
      prod_fb_q <= 17'(tap * fbk_s);
      d_in_q    <= dfd_pkg::sat16(18'(s16) - 18'(si_q));
    end
    if (cmd_i.fb) begin
      prod_in_q <= 25'(d_in_q * gain_s);
      d_out_q   <= dfd_pkg::sat16(18'(last_tap_q) - 18'(so_q));
    end
    if (cmd_i.upd_in) begin
      prod_out_q <= 25'(d_out_q * gain_s);
    end
    if (cmd_i.wet) begin
      prod_wet_q <= 25'(wet_src * wet_s);
    end
    if (cmd_i.load) begin
      out_q <= dfd_pkg::clip12(18'(sample_q) + 18'($signed(prod_wet_q[24:8])));
    end
  end

  // The write position always stays inside the line.
  a_wi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(wi_q) < LEN_E)
    else $error("write index outside the line");

endmodule

// ===== rtl/decimated_feedback_delay.sv =====
// Top level of the decimated feedback delay: configuration registers, the
// sequencer and the datapath. Depends on dfd_pkg, dfd_if, dfd_ctrl, dfd_datapath.
//
//  Channel  Dir  Payload                Transfer
//  in_i     in   sample_in (12b signed) in_i.valid & in_i.ready
//  out_o    out  sample_out(12b signed) out_o.valid & out_o.ready
//  cfg_i    in   index (3b), wdata(11b) cfg_i.valid & cfg_i.ready (always ready)
//
// After reset the line memory is cleared, one entry per cycle, over all LineLength
// entries (1280 by default); in_i.ready stays low until the last one is written.
// After the input transfer the steps run through the line memory read, the smoother
// multiplies and the wet multiply, and the final step loads the result register.
// A new sample is taken only after the final step of the previous one; a stalled
// output holds the sequence in its final step until the result register frees.
module decimated_feedback_delay #(
  parameter int LineLength = dfd_pkg::LINE_LENGTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfd_in_if.sink     in_i,
  dfd_out_if.source  out_o,
  dfd_cfg_if.sink    cfg_i
);

  dfd_pkg::cfg_t cfg_q;
  dfd_pkg::cmd_t cmd;
  dfd_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decimation   <= dfd_pkg::DECIMATION_RST;
      cfg_q.filter_gain  <= dfd_pkg::FILTER_GAIN_RST;
      cfg_q.delay_length <= dfd_pkg::DELAY_LENGTH_RST;
      cfg_q.feedback     <= dfd_pkg::FEEDBACK_RST;
      cfg_q.wet_amount   <= dfd_pkg::WET_AMOUNT_RST;
      cfg_q.raw_mode     <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dfd_pkg::CFG_DECIMATION:   cfg_q.decimation   <= cfg_i.wdata[7:0];
        dfd_pkg::CFG_FILTER_GAIN:  cfg_q.filter_gain  <= cfg_i.wdata[7:0];
        dfd_pkg::CFG_DELAY_LENGTH: cfg_q.delay_length <= cfg_i.wdata;
        dfd_pkg::CFG_FEEDBACK:     cfg_q.feedback     <= cfg_i.wdata[7:0];
        dfd_pkg::CFG_WET_AMOUNT:   cfg_q.wet_amount   <= cfg_i.wdata[7:0];
        dfd_pkg::CFG_RAW_MODE:     cfg_q.raw_mode     <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  dfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfd_datapath #(
    .LineLength(LineLength)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .sample_i(in_i.sample_in),
    .sample_o(out_o.sample_out)
  );

endmodule

// ===== tb/decimated_feedback_delay_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for decimated_feedback_delay: drives samples and register writes
// through the channel interfaces and checks every output sample against an in-bench model
// of the delay line, the smoothers and the wet mix. Depends on dfd_pkg, dfd_if and the RTL.
module decimated_feedback_delay_tb;

  localparam int LINE_LENGTH = dfd_pkg::LINE_LENGTH;
  localparam int SAMPLE_W    = dfd_pkg::SAMPLE_W;
  localparam int ENTRY_W     = dfd_pkg::ENTRY_W;
  localparam int COEF_W      = dfd_pkg::COEF_W;
  localparam int LEN_W       = dfd_pkg::LEN_W;
  localparam int CFG_IDX_W   = dfd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = dfd_pkg::CFG_DATA_W;

  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;
  localparam int SEGMENT_ITEMS = 170;
  localparam int HOLD_CYCLES   = 300;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  dfd_in_if  in_if ();
  dfd_out_if out_if ();
  dfd_cfg_if cfg_if ();

  decimated_feedback_delay uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model copy of the registers and of the echo state.
  dfd_pkg::cfg_t             echo_cfg;
  logic signed [ENTRY_W-1:0] line_mem [LINE_LENGTH];
  int                        wr_pos;
  int                        decim_cnt;
  int                        sm_in;
  int                        sm_out;
  int                        last_tap;

  logic signed [SAMPLE_W-1:0] echo_q [$];
  logic signed [SAMPLE_W-1:0] want;
  int                         mismatches = 0;
  int                         snd_idle_pct = 0;
  int                         rcv_stall_pct = 0;
  int                         hold_req = 0;
  int                         hold_cnt = 0;

  function automatic int sat_word(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clip_sample(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] predict_echo(
      input logic signed [SAMPLE_W-1:0] smp);
    int s;
    int s16;
    int span;
    int rd;
    int tap;
    int fb;
    int d;
    int wet;
    bit raw;
    s   = int'(smp);
    s16 = s * 16;
    raw = echo_cfg.raw_mode;
    if (decim_cnt >= int'(echo_cfg.decimation)) begin
      span = int'(echo_cfg.delay_length);
      if (span > LINE_LENGTH) span = LINE_LENGTH;
      // A distance of zero lands on the write position itself, like a full line.
      rd  = (wr_pos + LINE_LENGTH - span) % LINE_LENGTH;
      tap = int'(line_mem[rd]);
      decim_cnt = 0;
      fb = sat_word((raw ? s16 : sm_in) + ((tap * int'(echo_cfg.feedback)) >>> 8));
      line_mem[wr_pos] = ENTRY_W'(fb >>> 8);
      last_tap = tap * 16;
      wr_pos = (wr_pos + 1) % LINE_LENGTH;
    end
    if (!raw) begin
      d      = sat_word(s16 - sm_in);
      sm_in  = sat_word(sm_in + ((d * int'(echo_cfg.filter_gain)) >>> 8));
      d      = sat_word(last_tap - sm_out);
      sm_out = sat_word(sm_out + ((d * int'(echo_cfg.filter_gain)) >>> 8));
    end
    decim_cnt = (decim_cnt + 1) & 255;
    wet = ((raw ? last_tap : sm_out) * int'(echo_cfg.wet_amount)) >>> 8;
    return SAMPLE_W'(clip_sample(sat_word(s + wet)));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return -12'sd2048;
      1:       return 12'sd2047;
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic dfd_pkg::cfg_t rand_cfg();
    dfd_pkg::cfg_t c;
    case ($urandom_range(5))
      0:       c.decimation = 8'd0;
      1:       c.decimation = 8'd255;
      2:       c.decimation = 8'($urandom_range(255));
      default: c.decimation = 8'($urandom_range(1, 3));
    endcase
    case ($urandom_range(4))
      0:       c.filter_gain = 8'd0;
      1:       c.filter_gain = 8'd255;
      default: c.filter_gain = 8'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0:       c.delay_length = 11'd0;
      1:       c.delay_length = 11'd1280;
      2:       c.delay_length = 11'd2047;
      3:       c.delay_length = 11'($urandom_range(1281, 2047));
      4:       c.delay_length = 11'($urandom_range(1, 1279));
      default: c.delay_length = 11'($urandom_range(1, 24));
    endcase
    case ($urandom_range(5))
      0:       c.feedback = 8'd0;
      1:       c.feedback = 8'd85;
      2:       c.feedback = 8'd224;
      3:       c.feedback = 8'd255;
      default: c.feedback = 8'($urandom_range(255));
    endcase
    c.wet_amount = ($urandom_range(4) == 0) ? 8'd255 : 8'($urandom_range(255));
    c.raw_mode   = 1'($urandom_range(1));
    return c;
  endfunction

  // Leaves valid high; the caller lowers it once the burst of writes is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      dfd_pkg::CFG_DECIMATION:   echo_cfg.decimation   = data[COEF_W-1:0];
      dfd_pkg::CFG_FILTER_GAIN:  echo_cfg.filter_gain  = data[COEF_W-1:0];
      dfd_pkg::CFG_DELAY_LENGTH: echo_cfg.delay_length = data[LEN_W-1:0];
      dfd_pkg::CFG_FEEDBACK:     echo_cfg.feedback     = data[COEF_W-1:0];
      dfd_pkg::CFG_WET_AMOUNT:   echo_cfg.wet_amount   = data[COEF_W-1:0];
      dfd_pkg::CFG_RAW_MODE:     echo_cfg.raw_mode     = data[0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry random junk, which the registers must drop.
  task automatic program_cfg(input dfd_pkg::cfg_t c, input bit spare);
    if (spare) begin
      write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
      write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    end
    write_reg(dfd_pkg::CFG_DECIMATION,   {3'($urandom_range(7)), c.decimation});
    write_reg(dfd_pkg::CFG_FILTER_GAIN,  {3'($urandom_range(7)), c.filter_gain});
    write_reg(dfd_pkg::CFG_DELAY_LENGTH, c.delay_length);
    write_reg(dfd_pkg::CFG_FEEDBACK,     {3'($urandom_range(7)), c.feedback});
    write_reg(dfd_pkg::CFG_WET_AMOUNT,   {3'($urandom_range(7)), c.wet_amount});
    write_reg(dfd_pkg::CFG_RAW_MODE,     {10'($urandom), c.raw_mode});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= smp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    echo_q.push_back(predict_echo(smp));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_sample(12'sd2047);
    send_sample(-12'sd2048);
    send_sample(12'sd0);
    send_sample(-12'sd1);
    drain();
  endtask

  task automatic test_raw_saturation();
    program_cfg('{8'd0, 8'd0, 11'd1, 8'd255, 8'd255, 1'b1}, 1'b1);
    repeat (3) send_sample(12'sd2047);
    repeat (3) send_sample(-12'sd2048);
    send_sample(12'sd1);
    drain();
  endtask

  task automatic test_filtered_extremes();
    program_cfg('{8'd0, 8'd255, 11'd1, 8'd224, 8'd255, 1'b0}, 1'b0);
    repeat (2) send_sample(12'sd2047);
    repeat (2) send_sample(-12'sd2048);
    drain();
    program_cfg('{8'd0, 8'd0, 11'd1, 8'd224, 8'd255, 1'b0}, 1'b0);
    send_sample(12'sd2047);
    drain();
  endtask

  task automatic test_tap_distance();
    // Zero distance and distances past the line end both read the write position.
    program_cfg('{8'd0, 8'd128, 11'd0, 8'd85, 8'd200, 1'b1}, 1'b0);
    send_sample(12'sd2047);
    send_sample(12'sd1000);
    drain();
    program_cfg('{8'd0, 8'd128, 11'd2047, 8'd85, 8'd200, 1'b1}, 1'b0);
    send_sample(-12'sd2048);
    send_sample(12'sd5);
    drain();
    program_cfg('{8'd255, 8'd128, 11'd2, 8'd85, 8'd200, 1'b0}, 1'b0);
    repeat (3) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_random_phases();
    int idle_tab [4] = '{0, 49, 0, 13};
    int stall_tab [4] = '{0, 0, 49, 13};
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct  = idle_tab[ph];
      rcv_stall_pct = stall_tab[ph];
      for (int seg = 0; seg < 2; seg++) begin
        program_cfg(rand_cfg(), 1'($urandom_range(1)));
        repeat (SEGMENT_ITEMS) send_sample(rand_sample());
        drain();
      end
    end
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    // The long output stall fills the pipeline and must hold off further input transfers.
    program_cfg('{8'd0, 8'd200, 11'd3, 8'd224, 8'd180, 1'b0}, 1'b0);
    hold_req = HOLD_CYCLES;
    repeat (60) send_sample(rand_sample());
    drain();
    repeat (20) send_sample(rand_sample());
    drain();
  endtask

  // Receiver: random stalls, plus long hold-offs counted here.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (echo_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected sample_out %0d with nothing pending", out_if.sample_out);
        end
      end else begin
        want = echo_q.pop_front();
        if (out_if.sample_out !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("sample_out mismatch: expected %0d, got %0d", want, out_if.sample_out);
          end
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("decimated_feedback_delay_tb failed");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.wdata    = '0;
    echo_cfg = '{dfd_pkg::DECIMATION_RST, dfd_pkg::FILTER_GAIN_RST,
                 dfd_pkg::DELAY_LENGTH_RST, dfd_pkg::FEEDBACK_RST,
                 dfd_pkg::WET_AMOUNT_RST, 1'b0};
    foreach (line_mem[i]) line_mem[i] = '0;
    wr_pos    = 0;
    decim_cnt = 0;
    sm_in     = 0;
    sm_out    = 0;
    last_tap  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_raw_saturation();
    test_filtered_extremes();
    test_tap_distance();
    test_random_phases();
    test_backpressure();

    if (mismatches == 0) begin
      $display("decimated_feedback_delay_tb passed");
    end else begin
      $display("decimated_feedback_delay_tb failed");
    end
    $finish;
  end

endmodule
